// ===== sv/rpr_pkg.sv =====
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared widths, constants and constant tables of the rotary position rotate
// unit.
// ----------------------------------------------------------------------------
package rpr_pkg;

   // field widths
   localparam int DATA_W   = 32;
   localparam int BASE_W   = 22;
   localparam int LANES_W  = 11;
   localparam int IDX_W    = 9;
   localparam int POS_W    = 17;
   localparam int FAC_W    = 24;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG2_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_LANES = 2'd1;
   localparam logic [BASE_W-1:0]    BASE_RST      = 22'd870970;
   localparam logic [LANES_W-1:0]   LANES_RST     = 11'd256;

   // parameter defaults
   localparam int DEF_MAX_ROTATED_LANES = 1024;
   localparam int DEF_MAX_POSITION      = 131072;

   // exponent E = base * i / (rot / 2), unsigned Q.16
   localparam int EXP_W      = BASE_W + IDX_W;
   localparam int EXP_FRAC_W = 16;
   localparam int M_W        = 33;
   localparam logic [M_W-1:0] M_ONE = 33'h1_0000_0000;

   // turns per position, Q0.48, and its divided form
   localparam int TURNS_W   = 47;
   localparam int DIV2_N_W  = TURNS_W + 16;
   localparam int PHASE_W   = 48;
   localparam logic [29:0]      INV_TWO_PI_Q32 = 30'd683565276;
   localparam logic [FAC_W-1:0] FAC_UNITY      = 24'h01_0000;

   // quarter-wave sine
   localparam int ANG_W     = 31;
   localparam int SIN_W     = 31;
   localparam int U_W       = 31;
   localparam int U2_W      = 32;
   localparam int SIN_TERMS = 5;
   localparam logic [ANG_W-1:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [30:0]      HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0]      SIN_LEAD    = 31'd27;
   localparam logic [30:0]      SIN_COEF [SIN_TERMS] = '{
      31'd2959, 31'd213044, 31'd8947849, 31'd178956971, 31'h4000_0000
   };

   // quadrant codes, bits 47..46 of the phase
   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;

   typedef logic [31:0] root_tab_type [EXP_FRAC_W];

   function automatic logic [63:0] isqrt64(input logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] b;
      rem = n;
      res = '0;
      for (int i = 31; i >= 0; i--) begin
         b = 64'd1 << (2 * i);
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   // entry k approximates 2^32 * 2^(-2^-(k+1))
   function automatic root_tab_type root_table();
      root_tab_type tab;
      logic [63:0]  c;
      c = 64'd1 << 31;
      for (int k = 0; k < EXP_FRAC_W; k++) begin
         c      = isqrt64(c << 32);
         tab[k] = c[31:0];
      end
      return tab;
   endfunction

   localparam root_tab_type EXP_ROOT = root_table();

endpackage

// ===== sv/rpr_div.sv =====
// ----------------------------------------------------------------------------
// rpr_div
// Pipelined restoring divider: STEP quotient bits per stage, sideband data
// travels with each transaction.
// ----------------------------------------------------------------------------
module rpr_div #(
   parameter int N_W    = 31,
   parameter int D_W    = 10,
   parameter int STEP   = 4,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [N_W-1:0]    in_num,
   input  logic [D_W-1:0]    in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [N_W-1:0]    out_quo,
   output logic [SIDE_W-1:0] out_side
);
   localparam int NSTG  = (N_W + STEP - 1) / STEP;
   localparam int PAD_W = NSTG * STEP;

   logic [NSTG-1:0]   v_ff;
   logic [SIDE_W-1:0] side_ff [NSTG];
   logic [PAD_W-1:0]  num_ff  [NSTG];
   logic [PAD_W-1:0]  quo_ff  [NSTG];
   logic [D_W-1:0]    rem_ff  [NSTG];
   logic [D_W-1:0]    den_ff  [NSTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int s = 1; s < NSTG; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   for (genvar s = 0; s < NSTG; s++) begin : g_stg
      logic [PAD_W-1:0] num_src;
      logic [PAD_W-1:0] quo_src;
      logic [D_W-1:0]   rem_src;
      logic [D_W-1:0]   den_src;
      logic [PAD_W-1:0] num_in;
      logic [PAD_W-1:0] quo_in;
      logic [D_W-1:0]   rem_in;
      logic [D_W:0]     trial;

      if (s == 0) begin : g_first
         assign num_src = PAD_W'(in_num);
         assign quo_src = '0;
         assign rem_src = '0;
         assign den_src = in_den;
      end else begin : g_next
         assign num_src = num_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
      end

      always_comb begin
         num_in = num_src;
         quo_in = quo_src;
         rem_in = rem_src;
         trial  = '0;
         for (int i = 0; i < STEP; i++) begin
            trial  = {rem_in, num_in[PAD_W-1]};
            num_in = num_in << 1;
            if (trial >= {1'b0, den_src}) begin
               trial  = trial - {1'b0, den_src};
               quo_in = {quo_in[PAD_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[PAD_W-2:0], 1'b0};
            end
            rem_in = trial[D_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[s] <= num_in;
            quo_ff[s] <= quo_in;
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
         end
      end
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_quo   = quo_ff[NSTG-1][N_W-1:0];
   assign out_side  = side_ff[NSTG-1];

endmodule

// ===== sv/rpr_freq.sv =====
// ----------------------------------------------------------------------------
// rpr_freq
// Frequency 2^-E from the exponent, one fraction bit per stage, then the
// shift by the integer part and the scale to turns per position.
// ----------------------------------------------------------------------------
module rpr_freq #(
   parameter int SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [rpr_pkg::EXP_W-1:0]   in_exp,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [rpr_pkg::TURNS_W-1:0] out_turns,
   output logic [SIDE_W-1:0]           out_side
);
   import rpr_pkg::*;

   localparam int NBITS = EXP_FRAC_W;
   localparam int INT_W = EXP_W - EXP_FRAC_W;
   localparam int NSTG  = NBITS + 2;

   logic [NSTG-1:0]    v_ff;
   logic [SIDE_W-1:0]  side_ff [NSTG];
   logic [M_W-1:0]     m_ff    [NBITS];
   logic [NBITS-1:0]   f_ff    [NBITS];
   logic [INT_W-1:0]   n_ff    [NBITS];
   logic [M_W-1:0]     freq_ff;
   logic [TURNS_W-1:0] turns_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int s = 1; s < NSTG; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // stage k folds in fraction bit NBITS-1-k
   for (genvar k = 0; k < NBITS; k++) begin : g_bit
      logic [M_W-1:0]   m_src;
      logic [NBITS-1:0] f_src;
      logic [INT_W-1:0] n_src;
      logic [M_W+31:0]  prod;

      if (k == 0) begin : g_first
         assign m_src = M_ONE;
         assign f_src = in_exp[NBITS-1:0];
         assign n_src = in_exp[EXP_W-1:NBITS];
      end else begin : g_next
         assign m_src = m_ff[k-1];
         assign f_src = f_ff[k-1];
         assign n_src = n_ff[k-1];
      end

      assign prod = (M_W + 32)'(m_src) * (M_W + 32)'(EXP_ROOT[k]);

      always_ff @(posedge clock) begin
         if (adv) begin
            m_ff[k] <= f_src[NBITS-1-k] ? M_W'(prod >> 32) : m_src;
            f_ff[k] <= f_src;
            n_ff[k] <= n_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         freq_ff  <= m_ff[NBITS-1] >> n_ff[NBITS-1];
         turns_ff <= TURNS_W'((63'(freq_ff) * 63'(INV_TWO_PI_Q32)) >> 16);
      end
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_turns = turns_ff;
   assign out_side  = side_ff[NSTG-1];

endmodule

// ===== sv/rpr_sin.sv =====
// ----------------------------------------------------------------------------
// rpr_sin
// Two-lane quarter-wave sine: odd Taylor series by Horner, one multiply per
// stage.
// ----------------------------------------------------------------------------
module rpr_sin #(
   parameter int SIDE_W = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic [1:0][rpr_pkg::ANG_W-1:0]  in_angle,
   input  logic [SIDE_W-1:0]               in_side,
   output logic                            out_valid,
   output logic [1:0][rpr_pkg::SIN_W-1:0]  out_sin,
   output logic [SIDE_W-1:0]               out_side
);
   import rpr_pkg::*;

   localparam int NSTG = SIN_TERMS + 3;

   logic [NSTG-1:0]   v_ff;
   logic [SIDE_W-1:0] side_ff [NSTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int s = 1; s < NSTG; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [U_W-1:0]   u_ff  [NSTG-1];
      logic [U2_W-1:0]  u2_ff [SIN_TERMS];
      logic [30:0]      t_ff  [SIN_TERMS];
      logic [SIN_W-1:0] s_ff;
      logic [63:0]      fin;

      assign fin = (64'(u_ff[NSTG-2]) * 64'(t_ff[SIN_TERMS-1])) >> 30;

      always_ff @(posedge clock) begin
         if (adv) begin
            u_ff[0] <= U_W'((64'(in_angle[l]) * 64'(HALF_PI_Q30)) >> 30);
            for (int s = 1; s < NSTG - 1; s++) begin
               u_ff[s] <= u_ff[s-1];
            end
            u2_ff[0] <= U2_W'((64'(u_ff[0]) * 64'(u_ff[0])) >> 30);
            for (int s = 1; s < SIN_TERMS; s++) begin
               u2_ff[s] <= u2_ff[s-1];
            end
            t_ff[0] <= 31'(64'(SIN_COEF[0])
                           - ((64'(SIN_LEAD) * 64'(u2_ff[0])) >> 30));
            for (int j = 1; j < SIN_TERMS; j++) begin
               t_ff[j] <= 31'(64'(SIN_COEF[j])
                              - ((64'(t_ff[j-1]) * 64'(u2_ff[j])) >> 30));
            end
            // clamp to one
            s_ff <= (fin > 64'(ONE_Q30)) ? ONE_Q30 : SIN_W'(fin);
         end
      end

      assign out_sin[l] = s_ff;
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_side  = side_ff[NSTG-1];

endmodule

// ===== sv/rotary_position_rotate_unit.sv =====
// ----------------------------------------------------------------------------
// rotary_position_rotate_unit
// Rotates one lane pair of a head by position * base^(-2i/rot), optionally
// divided by a per-lane factor, in Q16.16 with rounding and saturation.
// The unit takes one transaction per clock while the result side is not
// stalled and returns one result per transaction, in order, through an entry
// register, the exponent divider (8 stages), the frequency chain (18), the
// factor divider (21), the phase multiply (1), the sine pipeline (8), quadrant
// select (1), the rotation multiplies (1) and the rounding output register
// (1). A stall on the result side holds the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module rotary_position_rotate_unit #(
   parameter int MAX_ROTATED_LANES = rpr_pkg::DEF_MAX_ROTATED_LANES,
   parameter int MAX_POSITION      = rpr_pkg::DEF_MAX_POSITION
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rpr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rpr_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [rpr_pkg::DATA_W-1:0]    req_first_value,
   input  logic signed [rpr_pkg::DATA_W-1:0]    req_second_value,
   input  logic [rpr_pkg::IDX_W-1:0]            req_pair_index,
   input  logic [rpr_pkg::POS_W-1:0]            req_position,
   input  logic                                 req_use_factor,
   input  logic [rpr_pkg::FAC_W-1:0]            req_freq_factor,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rpr_pkg::DATA_W-1:0]    rsp_rotated_first,
   output logic signed [rpr_pkg::DATA_W-1:0]    rsp_rotated_second
);
   import rpr_pkg::*;

   localparam int POS_LOG = $clog2(MAX_POSITION);
   localparam int POSC_W  = (POS_LOG < POS_W) ? POS_LOG : POS_W;
   localparam int ROT_LOG = $clog2(MAX_ROTATED_LANES + 1);
   localparam int ROT_W   = (ROT_LOG > LANES_W) ? ROT_LOG : LANES_W;
   localparam int DIV_W   = $clog2(MAX_ROTATED_LANES / 2 + 1);

   typedef struct packed {
      logic signed [DATA_W-1:0] first;
      logic signed [DATA_W-1:0] second;
      logic [POSC_W-1:0]        pos;
      logic [FAC_W-1:0]         den;
   } ent_side_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] first;
      logic signed [DATA_W-1:0] second;
      logic [POSC_W-1:0]        pos;
   } ph_side_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] first;
      logic signed [DATA_W-1:0] second;
      logic [1:0]               quad;
   } sin_side_type;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [BASE_W-1:0]  base_ff;
   logic [LANES_W-1:0] lanes_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RST;
         lanes_ff <= LANES_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LOG2_BASE: base_ff  <= csr_data[BASE_W-1:0];
            CSR_ROT_LANES: lanes_ff <= csr_data[LANES_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // pipeline control: everything advances when the output can move
   // ------------------------------------------------------------------
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ------------------------------------------------------------------
   // entry stage
   // ------------------------------------------------------------------
   logic [ROT_W-1:0]  rot_even;
   logic [ROT_W-1:0]  rot_lim;
   logic [DIV_W-1:0]  half_in;
   logic [EXP_W-1:0]  prod_in;
   logic [POSC_W-1:0] pos_in;
   ent_side_type      side_in;

   logic              ent_v_ff;
   logic [EXP_W-1:0]  ent_prod_ff;
   logic [DIV_W-1:0]  ent_half_ff;
   ent_side_type      ent_side_ff;

   always_comb begin
      rot_even = ROT_W'({lanes_ff[LANES_W-1:1], 1'b0});
      if (rot_even < ROT_W'(2)) begin
         rot_lim = ROT_W'(2);
      end else if (rot_even > ROT_W'(MAX_ROTATED_LANES)) begin
         rot_lim = ROT_W'(MAX_ROTATED_LANES);
      end else begin
         rot_lim = rot_even;
      end
      half_in = DIV_W'(rot_lim >> 1);
      prod_in = EXP_W'(base_ff) * EXP_W'(req_pair_index);
      pos_in  = (32'(req_position) >= 32'(MAX_POSITION))
                ? POSC_W'(MAX_POSITION - 1) : POSC_W'(req_position);
      side_in.first  = req_first_value;
      side_in.second = req_second_value;
      side_in.pos    = pos_in;
      // a divisor of one in Q8.16 leaves the turns unchanged
      side_in.den    = (req_use_factor && req_freq_factor != '0)
                       ? req_freq_factor : FAC_UNITY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_v_ff <= 1'b0;
      end else if (adv) begin
         ent_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ent_prod_ff <= prod_in;
         ent_half_ff <= half_in;
         ent_side_ff <= side_in;
      end
   end

   // ------------------------------------------------------------------
   // exponent, frequency and factor division
   // ------------------------------------------------------------------
   logic               e_v;
   logic [EXP_W-1:0]   e_quo;
   ent_side_type       e_side;
   logic               t_v;
   logic [TURNS_W-1:0] t_turns;
   ent_side_type       t_side;
   logic               d_v;
   logic [DIV2_N_W-1:0] d_quo;
   ph_side_type        d_side_in;
   ph_side_type        d_side;

   rpr_div #(
      .N_W    (EXP_W),
      .D_W    (DIV_W),
      .STEP   (4),
      .SIDE_W ($bits(ent_side_type))
   ) u_exp_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (ent_v_ff),
      .in_num    (ent_prod_ff),
      .in_den    (ent_half_ff),
      .in_side   (ent_side_ff),
      .out_valid (e_v),
      .out_quo   (e_quo),
      .out_side  (e_side)
   );

   rpr_freq #(
      .SIDE_W ($bits(ent_side_type))
   ) u_freq (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (e_v),
      .in_exp    (e_quo),
      .in_side   (e_side),
      .out_valid (t_v),
      .out_turns (t_turns),
      .out_side  (t_side)
   );

   assign d_side_in.first  = t_side.first;
   assign d_side_in.second = t_side.second;
   assign d_side_in.pos    = t_side.pos;

   rpr_div #(
      .N_W    (DIV2_N_W),
      .D_W    (FAC_W),
      .STEP   (3),
      .SIDE_W ($bits(ph_side_type))
   ) u_fac_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (t_v),
      .in_num    ({t_turns, 16'h0000}),
      .in_den    (t_side.den),
      .in_side   (d_side_in),
      .out_valid (d_v),
      .out_quo   (d_quo),
      .out_side  (d_side)
   );

   // ------------------------------------------------------------------
   // phase, wrapped to one turn
   // ------------------------------------------------------------------
   logic                     ph_v_ff;
   logic [PHASE_W-1:0]       phase_ff;
   logic signed [DATA_W-1:0] ph_first_ff;
   logic signed [DATA_W-1:0] ph_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_v_ff <= 1'b0;
      end else if (adv) begin
         ph_v_ff <= d_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         phase_ff     <= PHASE_W'(PHASE_W'(d_side.pos) * d_quo[PHASE_W-1:0]);
         ph_first_ff  <= d_side.first;
         ph_second_ff <= d_side.second;
      end
   end

   // ------------------------------------------------------------------
   // sine of the fraction and of its complement
   // ------------------------------------------------------------------
   logic [1:0][ANG_W-1:0] angle;
   sin_side_type          sin_side_in;
   logic                  s_v;
   logic [1:0][SIN_W-1:0] s_val;
   sin_side_type          s_side;

   assign angle[0]           = ANG_W'(phase_ff[PHASE_W-3 -: 30]);
   assign angle[1]           = ONE_Q30 - ANG_W'(phase_ff[PHASE_W-3 -: 30]);
   assign sin_side_in.first  = ph_first_ff;
   assign sin_side_in.second = ph_second_ff;
   assign sin_side_in.quad   = phase_ff[PHASE_W-1 -: 2];

   rpr_sin #(
      .SIDE_W ($bits(sin_side_type))
   ) u_sin (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (ph_v_ff),
      .in_angle  (angle),
      .in_side   (sin_side_in),
      .out_valid (s_v),
      .out_sin   (s_val),
      .out_side  (s_side)
   );

   // ------------------------------------------------------------------
   // quadrant select
   // ------------------------------------------------------------------
   logic signed [DATA_W-1:0] sa;
   logic signed [DATA_W-1:0] sb;
   logic signed [DATA_W-1:0] sn_in;
   logic signed [DATA_W-1:0] cs_in;
   logic                     sel_v_ff;
   logic signed [DATA_W-1:0] sn_ff;
   logic signed [DATA_W-1:0] cs_ff;
   logic signed [DATA_W-1:0] sel_first_ff;
   logic signed [DATA_W-1:0] sel_second_ff;

   always_comb begin
      sa = signed'({1'b0, s_val[0]});
      sb = signed'({1'b0, s_val[1]});
      case (s_side.quad)
         QUAD_FIRST: begin
            sn_in = sa;
            cs_in = sb;
         end
         QUAD_SECOND: begin
            sn_in = sb;
            cs_in = -sa;
         end
         QUAD_THIRD: begin
            sn_in = -sa;
            cs_in = -sb;
         end
         default: begin
            sn_in = -sb;
            cs_in = sa;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_v_ff <= 1'b0;
      end else if (adv) begin
         sel_v_ff <= s_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sn_ff         <= sn_in;
         cs_ff         <= cs_in;
         sel_first_ff  <= s_side.first;
         sel_second_ff <= s_side.second;
      end
   end

   // ------------------------------------------------------------------
   // rotation products
   // ------------------------------------------------------------------
   logic               mul_v_ff;
   logic signed [63:0] pc_ff;
   logic signed [63:0] qs_ff;
   logic signed [63:0] ps_ff;
   logic signed [63:0] qc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
      end else if (adv) begin
         mul_v_ff <= sel_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pc_ff <= 64'(sel_first_ff) * 64'(cs_ff);
         qs_ff <= 64'(sel_second_ff) * 64'(sn_ff);
         ps_ff <= 64'(sel_first_ff) * 64'(sn_ff);
         qc_ff <= 64'(sel_second_ff) * 64'(cs_ff);
      end
   end

   // ------------------------------------------------------------------
   // round Q46 to Q16 and saturate
   // ------------------------------------------------------------------
   function automatic logic signed [DATA_W-1:0] round_sat(
      input logic signed [63:0] v
   );
      logic signed [63:0] r;
      r = (v + 64'sd536870912) >>> 30;
      if (r > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (r < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return r[DATA_W-1:0];
   endfunction

   logic signed [DATA_W-1:0] first_ff;
   logic signed [DATA_W-1:0] second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mul_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         first_ff  <= round_sat(pc_ff - qs_ff);
         second_ff <= round_sat(ps_ff + qc_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rotated_first  = first_ff;
   assign rsp_rotated_second = second_ff;

endmodule
